>>> sv/fbfl_pkg.sv
// shared types and constants for the fixed block free list allocator
// no dependencies
package fbfl_pkg;

    localparam int MAX_BLOCKS_DEF = 64;

    localparam int MODE_W     = 2;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int ADDR_W     = 32;
    localparam int BYTES_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INIT  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 2'd2;

    localparam logic [ADDR_W-1:0]  RESET_BASE   = 32'd0;
    localparam logic [BYTES_W-1:0] RESET_BYTES  = 16'd4;
    localparam logic [CNT_W-1:0]   RESET_BLOCKS = 7'd64;
    localparam logic [CNT_W-1:0]   RESET_FREE   = 7'd64;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_INIT,
        OP_NOP,
        OP_RANGE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] index;
        logic [CNT_W-1:0] count;
    } t_cmd;

endpackage

>>> sv/fixed_block_free_list_allocator.sv
// fixed size block allocator: lifo free list held in a link memory
// items pass the queue, then the result register; a granted alloc passes S_READ first
// throughput: one item a cycle unless stalled; a granted alloc holds pops in S_READ
// reset: synchronous, active low; link entries fall back to their default link at once
// depends on fbfl_pkg, fbfl_front, fbfl_queue, fbfl_back
module fixed_block_free_list_allocator #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [fbfl_pkg::MODE_W-1:0]      i_mode,
    input  logic [fbfl_pkg::IDX_W-1:0]       i_block_index,
    input  logic                             i_null_pointer,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_granted,
    output logic [fbfl_pkg::IDX_W-1:0]       o_given_index,
    output logic [fbfl_pkg::ADDR_W-1:0]      o_given_address,
    output logic [fbfl_pkg::CNT_W-1:0]       o_blocks_free,
    output logic [fbfl_pkg::STATUS_W-1:0]    o_status,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fbfl_pkg::*;

    logic [ADDR_W-1:0]  r_base_address;
    logic [BYTES_W-1:0] r_block_bytes;
    logic [CNT_W-1:0]   r_blocks_in_use;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_cmd front_cmd;
    t_cmd back_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_address  <= RESET_BASE;
            r_block_bytes   <= RESET_BYTES;
            r_blocks_in_use <= RESET_BLOCKS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BASE:   r_base_address  <= i_cfg_data[ADDR_W-1:0];
                CFG_BYTES:  r_block_bytes   <= i_cfg_data[BYTES_W-1:0];
                CFG_BLOCKS: r_blocks_in_use <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    fbfl_front #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_front (
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_block_index   (i_block_index),
        .i_null_pointer  (i_null_pointer),
        .i_blocks_in_use (r_blocks_in_use),
        .i_queue_full    (q_full),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    fbfl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (back_cmd),
        .o_empty (q_empty)
    );

    fbfl_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (back_cmd),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .i_base_address  (r_base_address),
        .i_block_bytes   (r_block_bytes),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_granted       (o_granted),
        .o_given_index   (o_given_index),
        .o_given_address (o_given_address),
        .o_blocks_free   (o_blocks_free),
        .o_status        (o_status)
    );

endmodule

>>> sv/fbfl_ram.sv
// generic single write port ram with registered read
// no dependencies
module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/fbfl_front.sv
// front end: accepts request items and classifies them into commands
// depends on fbfl_pkg
module fbfl_front #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [fbfl_pkg::MODE_W-1:0]  i_mode,
    input  logic [fbfl_pkg::IDX_W-1:0]   i_block_index,
    input  logic                         i_null_pointer,
    input  logic [fbfl_pkg::CNT_W-1:0]   i_blocks_in_use,
    input  logic                         i_queue_full,
    output logic                         o_push,
    output fbfl_pkg::t_cmd               o_cmd
);
    import fbfl_pkg::*;

    localparam int CLAMP = (MAX_BLOCKS > 127) ? 127 : MAX_BLOCKS;

    logic [CNT_W-1:0] carved;

    assign carved  = (i_blocks_in_use > CNT_W'(CLAMP)) ? CNT_W'(CLAMP) : i_blocks_in_use;
    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_cmd.index = i_block_index;
        o_cmd.count = carved;
        unique case (i_mode)
            MODE_ALLOC: o_cmd.op = OP_ALLOC;
            MODE_FREE: begin
                if (i_null_pointer) begin
                    o_cmd.op = OP_NOP;
                end else if ({1'b0, i_block_index} >= carved) begin
                    o_cmd.op = OP_RANGE;
                end else begin
                    o_cmd.op = OP_FREE;
                end
            end
            MODE_INIT: o_cmd.op = OP_INIT;
            default:   o_cmd.op = OP_NOP;
        endcase
    end

endmodule

>>> sv/fbfl_queue.sv
// two entry command queue between front end and back end
// depends on fbfl_pkg
module fbfl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fbfl_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output fbfl_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import fbfl_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_cmd              r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_QW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/fbfl_back.sv
// back end: runs commands against the free list and holds the result register
// depends on fbfl_pkg and fbfl_ram
module fbfl_back #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fbfl_pkg::t_cmd                 i_cmd,
    input  logic                           i_empty,
    output logic                           o_pop,
    input  logic [fbfl_pkg::ADDR_W-1:0]    i_base_address,
    input  logic [fbfl_pkg::BYTES_W-1:0]   i_block_bytes,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_granted,
    output logic [fbfl_pkg::IDX_W-1:0]     o_given_index,
    output logic [fbfl_pkg::ADDR_W-1:0]    o_given_address,
    output logic [fbfl_pkg::CNT_W-1:0]     o_blocks_free,
    output logic [fbfl_pkg::STATUS_W-1:0]  o_status
);
    import fbfl_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [IW-1:0]        r_head, n_head;
    logic                 r_empty, n_empty;
    logic [CNT_W-1:0]     r_free_total, n_free_total;
    logic [MAX_BLOCKS-1:0] r_link_ok, n_link_ok;
    logic [ADDR_W-1:0]    r_prod;

    logic                 r_out_valid;
    logic                 r_granted, n_granted;
    logic [IDX_W-1:0]     r_gidx, n_gidx;
    logic [ADDR_W-1:0]    r_gaddr, n_gaddr;
    logic [CNT_W-1:0]     r_bfree;
    logic [STATUS_W-1:0]  r_status, n_status;

    logic                 out_free;
    logic                 load;
    logic                 ram_we;
    logic [IW-1:0]        cmd_idx;
    logic [IW-1:0]        rdata;
    logic [IW-1:0]        dflt_link;
    logic [IW-1:0]        link;
    logic [CNT_W-1:0]     dec_total;

    assign out_free  = !r_out_valid || !i_stall;
    assign o_pop     = (r_state == S_IDLE) && !i_empty && out_free;
    assign cmd_idx   = IW'(i_cmd.index);
    assign ram_we    = o_pop && (i_cmd.op == OP_FREE);
    assign dflt_link = (r_head == IW'(MAX_BLOCKS - 1)) ? '0 : r_head + 1'b1;
    assign link      = r_link_ok[r_head] ? rdata : dflt_link;
    assign dec_total = r_free_total - 1'b1;

    fbfl_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_BLOCKS)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cmd_idx),
        .i_wdata (r_head),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_empty      = r_empty;
        n_free_total = r_free_total;
        n_link_ok    = r_link_ok;
        load         = 1'b0;
        n_granted    = 1'b0;
        n_gidx       = '0;
        n_gaddr      = '0;
        n_status     = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    case (i_cmd.op)
                        OP_ALLOC: begin
                            if (r_empty) begin
                                load     = 1'b1;
                                n_status = ST_EXHAUSTED;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        OP_FREE: begin
                            n_link_ok[cmd_idx] = 1'b1;
                            n_head             = cmd_idx;
                            n_free_total       = r_free_total + 1'b1;
                            n_empty            = 1'b0;
                            load               = 1'b1;
                        end
                        OP_INIT: begin
                            n_link_ok    = '0;
                            n_head       = '0;
                            n_free_total = i_cmd.count;
                            n_empty      = (i_cmd.count == '0);
                            load         = 1'b1;
                        end
                        OP_RANGE: begin
                            n_status = ST_RANGE;
                            load     = 1'b1;
                        end
                        default: load = 1'b1;
                    endcase
                end
            end
            S_READ: begin
                n_head       = link;
                n_free_total = dec_total;
                n_empty      = (dec_total == '0);
                n_granted    = 1'b1;
                n_gidx       = IDX_W'(r_head);
                n_gaddr      = i_base_address + r_prod;
                load         = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_empty      <= 1'b0;
            r_free_total <= RESET_FREE;
            r_link_ok    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_empty      <= n_empty;
            r_free_total <= n_free_total;
            r_link_ok    <= n_link_ok;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= ADDR_W'(r_head) * ADDR_W'(i_block_bytes);
        if (load) begin
            r_granted <= n_granted;
            r_gidx    <= n_gidx;
            r_gaddr   <= n_gaddr;
            r_bfree   <= n_free_total;
            r_status  <= n_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_granted       = r_granted;
    assign o_given_index   = r_gidx;
    assign o_given_address = r_gaddr;
    assign o_blocks_free   = r_bfree;
    assign o_status        = r_status;

endmodule

>>> sv/fbfl_checker.sv
// port level checks on the allocator result channel, bound to the top level
// depends on fbfl_pkg and fixed_block_free_list_allocator
module fbfl_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic                            o_granted,
    input logic [fbfl_pkg::IDX_W-1:0]      o_given_index,
    input logic [fbfl_pkg::ADDR_W-1:0]     o_given_address,
    input logic [fbfl_pkg::CNT_W-1:0]      o_blocks_free,
    input logic [fbfl_pkg::STATUS_W-1:0]   o_status
);
    import fbfl_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_given_address) && $stable(o_status))
        else $error("result changed while stalled");

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_granted |-> o_given_index == '0 && o_given_address == '0)
        else $error("refused item carries an index or address");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_granted |-> o_status == ST_OK)
        else $error("granted item with error status");

    a_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EXHAUSTED |-> o_blocks_free == '0)
        else $error("pool exhausted with free blocks left");

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_granted       (o_granted),
    .o_given_index   (o_given_index),
    .o_given_address (o_given_address),
    .o_blocks_free   (o_blocks_free),
    .o_status        (o_status)
);
